// ----- rtl/core/lmr_pkg.sv -----
package lmr_pkg;

  localparam int COORD_BITS = 6;
  // decision value range: |D| stays well below 2^(2*COORD_BITS+3)
  localparam int DEC_W = 2 * COORD_BITS + 4;
  localparam int IN_TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [DEC_W-1:0] dec_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

endpackage

// ----- rtl/core/lmr_addsub.sv -----
module lmr_addsub
  import lmr_pkg::*;
(
  input  dec_t opa,
  input  dec_t opb,
  input  logic sub,
  output dec_t sum
);

  dec_t opb_inv;

  assign opb_inv = opb ^ {DEC_W{sub}};
  assign sum = opa + opb_inv + dec_t'(sub);

endmodule

// ----- rtl/core/lmr_ctrl.sv -----
module lmr_ctrl
  import lmr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   seg_valid,
  output logic   seg_ready,
  input  coord_t seg_x0,
  input  coord_t seg_y0,
  input  coord_t seg_x1,
  input  coord_t seg_y1,
  output logic   pix_valid,
  input  logic   pix_ready,
  output pixel_t pix
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_A    = 3'd1;
  localparam logic [2:0] ST_B    = 3'd2;
  localparam logic [2:0] ST_MAJ  = 3'd3;
  localparam logic [2:0] ST_M    = 3'd4;
  localparam logic [2:0] ST_C    = 3'd5;
  localparam logic [2:0] ST_D    = 3'd6;
  localparam logic [2:0] ST_RUN  = 3'd7;

  logic [2:0] state_r, state_nxt;
  coord_t x_r, y_r, xe_r, ye_r;
  coord_t x_nxt, y_nxt, xe_nxt, ye_nxt;
  dec_t a_r, b_r, m_r, c_r, d_r;
  dec_t a_nxt, b_nxt, m_nxt, c_nxt, d_nxt;
  logic xmaj_r, xmaj_nxt;

  dec_t opa, opb, sum;
  logic sub;
  logic swap, a_neg, a_pos, d_neg, d_zero, step, last, fire;
  dec_t a2, b2;

  lmr_addsub u_addsub (
    .opa (opa),
    .opb (opb),
    .sub (sub),
    .sum (sum)
  );

  assign a2 = a_r <<< 1;
  assign b2 = b_r <<< 1;
  assign a_neg = a_r[DEC_W-1];
  assign a_pos = !a_neg && (a_r != '0);
  assign d_neg = d_r[DEC_W-1];
  assign d_zero = (d_r == '0);
  assign swap = seg_x0 > seg_x1;

  // midpoint test on the current pixel
  always_comb begin
    if (xmaj_r) begin
      step = a_neg ? d_neg : !d_neg;
    end else begin
      step = a_neg ? (!d_neg && !d_zero) : (d_neg || d_zero);
    end
  end

  assign last = xmaj_r ? (x_r == xe_r) : (y_r == ye_r);
  assign seg_ready = (state_r == ST_IDLE);
  assign pix_valid = (state_r == ST_RUN);
  assign fire = pix_valid && pix_ready;
  assign pix.x = x_r;
  assign pix.y = y_r;
  assign pix.last = last;

  // shared adder operand select
  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    unique case (state_r)
      ST_A: begin
        opa = dec_t'(y_r);
        opb = dec_t'(ye_r);
        sub = 1'b1;
      end
      ST_B: begin
        opa = dec_t'(xe_r);
        opb = dec_t'(x_r);
        sub = 1'b1;
      end
      ST_MAJ: begin
        opa = a_r;
        opb = b_r;
      end
      ST_M: begin
        if (xmaj_r) begin
          opa = a2;
        end else begin
          opb = b2;
          sub = a_pos;
        end
      end
      ST_C: begin
        opa = m_r;
        if (xmaj_r) begin
          opb = b2;
          sub = !a_neg;
        end else begin
          opb = a2;
        end
      end
      ST_D: begin
        opa = a2;
        opb = b_r;
      end
      ST_RUN: begin
        opa = d_r;
        opb = step ? c_r : m_r;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;
    y_nxt = y_r;
    xe_nxt = xe_r;
    ye_nxt = ye_r;
    a_nxt = a_r;
    b_nxt = b_r;
    m_nxt = m_r;
    c_nxt = c_r;
    d_nxt = d_r;
    xmaj_nxt = xmaj_r;
    unique case (state_r)
      ST_IDLE: begin
        if (seg_valid) begin
          x_nxt = swap ? seg_x1 : seg_x0;
          y_nxt = swap ? seg_y1 : seg_y0;
          xe_nxt = swap ? seg_x0 : seg_x1;
          ye_nxt = swap ? seg_y0 : seg_y1;
          state_nxt = ST_A;
        end
      end
      ST_A: begin
        a_nxt = sum;
        state_nxt = ST_B;
      end
      ST_B: begin
        b_nxt = sum;
        state_nxt = ST_MAJ;
      end
      ST_MAJ: begin
        // b > |a| when b > a and b > -a
        xmaj_nxt = (b_r > a_r) && !sum[DEC_W-1] && (sum != '0);
        state_nxt = ST_M;
      end
      ST_M: begin
        m_nxt = sum;
        state_nxt = ST_C;
      end
      ST_C: begin
        c_nxt = sum;
        state_nxt = ST_D;
      end
      ST_D: begin
        d_nxt = sum;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (fire) begin
          d_nxt = sum;
          if (xmaj_r) begin
            x_nxt = x_r + coord_t'(1);
            if (step) begin
              y_nxt = a_neg ? y_r + coord_t'(1) : y_r - coord_t'(1);
            end
          end else begin
            y_nxt = a_pos ? y_r - coord_t'(1) : y_r + coord_t'(1);
            if (step) begin
              x_nxt = x_r + coord_t'(1);
            end
          end
          if (last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    xe_r <= xe_nxt;
    ye_r <= ye_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    m_r <= m_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    xmaj_r <= xmaj_nxt;
  end

endmodule

// ----- rtl/core/line_midpoint_rasterizer_core.sv -----
// channel | dir | tdata (low bit up)                    | tuser | tlast
// in_     | in  | start_x, start_y, end_x, end_y        | -     | -
// out_    | out | pixel_x, pixel_y, zero pad            | -     | last_pixel
//
// a line yields n pixels, n = |major difference| + 1 (up to 64), after six setup steps
// (A, B, MAJ, M, C, D) on the single shared adder, then one pixel per cycle while out_tready
// allows, through the output register.
// in_tready is high only while no line is being walked.
// a stalled out_tready holds the output register and freezes the walk.
// rst_n is synchronous and clears the sequencer and the output valid.
module line_midpoint_rasterizer_core
  import lmr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // start_x, start_y, end_x, end_y
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata, // pixel_x, pixel_y, zero pad
  output logic                   out_tlast
);

  logic   pix_valid, pix_ready;
  pixel_t pix;
  logic   out_valid_r;
  pixel_t out_pix_r;

  lmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .seg_valid (in_tvalid),
    .seg_ready (in_tready),
    .seg_x0    (in_tdata[COORD_BITS-1:0]),
    .seg_y0    (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .seg_x1    (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .seg_y1    (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  // output register takes a new pixel when empty or draining
  assign pix_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pix_ready) begin
      out_valid_r <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready && pix_valid) begin
      out_pix_r <= pix;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = OUT_TDATA_W'({out_pix_r.y, out_pix_r.x});
  assign out_tlast = out_pix_r.last;

endmodule

// ----- tb/testbench.sv -----
module testbench
  import lmr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [IN_TDATA_W-1:0] seg_word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;  // start_x, start_y, end_x, end_y
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // pixel_x, pixel_y, zero pad
  logic                   out_tlast;

  seg_word_t segment_q[$];
  pixel_t    pixel_q[$];
  int        mismatch_cnt = 0;

  line_midpoint_rasterizer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic seg_word_t pack_segment(int sx, int sy, int ex, int ey);
    seg_word_t w;
    w = '0;
    w[0*COORD_BITS +: COORD_BITS] = coord_t'(sx);
    w[1*COORD_BITS +: COORD_BITS] = coord_t'(sy);
    w[2*COORD_BITS +: COORD_BITS] = coord_t'(ex);
    w[3*COORD_BITS +: COORD_BITS] = coord_t'(ey);
    return w;
  endfunction

  function automatic void queue_segment(int sx, int sy, int ex, int ey);
    segment_q = {segment_q, pack_segment(sx, sy, ex, ey)};
  endfunction

  function automatic void queue_pixel(pixel_t p);
    pixel_q = {pixel_q, p};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 7) != 0)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return (1 << COORD_BITS) - 1;
      default: return $urandom_range(0, (1 << COORD_BITS) - 1);
    endcase
  endfunction

  function automatic int near_coord(int base);
    int v;
    v = base + $signed($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
    return v;
  endfunction

  // walks one segment and queues every pixel it should produce
  task automatic rasterize_segment(seg_word_t w);
    int x0, y0, x1, y1, tmp;
    int a, b, c, x, y, dy, dval;
    pixel_t pix;
    x0 = int'(w[0*COORD_BITS +: COORD_BITS]);
    y0 = int'(w[1*COORD_BITS +: COORD_BITS]);
    x1 = int'(w[2*COORD_BITS +: COORD_BITS]);
    y1 = int'(w[3*COORD_BITS +: COORD_BITS]);
    if (x0 > x1) begin
      tmp = x0; x0 = x1; x1 = tmp;
      tmp = y0; y0 = y1; y1 = tmp;
    end
    a = y0 - y1;
    b = x1 - x0;
    c = x0 * y1 - x1 * y0;
    x = x0;
    y = y0;
    pix.last = 1'b0;
    if ((b < 0 ? -b : b) > (a < 0 ? -a : a)) begin
      for (; x <= x1; x++) begin
        pix.x = x[COORD_BITS-1:0];
        pix.y = y[COORD_BITS-1:0];
        queue_pixel(pix);
        dval = 2 * a * (x + 1) + b * (2 * y + 1) + 2 * c;
        if (a < 0) begin
          if (dval < 0) y++;
        end else begin
          if (dval >= 0) y--;
        end
      end
    end else begin
      dy = (y1 - y0) < 0 ? -1 : 1;
      for (; y != y1 + dy; y += dy) begin
        pix.x = x[COORD_BITS-1:0];
        pix.y = y[COORD_BITS-1:0];
        queue_pixel(pix);
        dval = 2 * a * (x + 1) + b * (2 * y + 1) + 2 * c;
        if (a < 0) begin
          if (dval > 0) x++;
        end else begin
          if (dval <= 0) x++;
        end
      end
    end
    pixel_q[pixel_q.size()-1].last = 1'b1;
  endtask

  // sender
  int segs_sent = 0;
  int send_gap = 0;

  always @(posedge clk) begin
    logic      valid_next;
    seg_word_t data_next;
    valid_next = in_tvalid;
    data_next = in_tdata;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        rasterize_segment(in_tdata);
        segs_sent++;
        valid_next = 1'b0;
        // no idling on the sender for a stretch in the middle of the run
        if (!(segs_sent >= 100 && segs_sent < 130) && $urandom_range(0, 1) == 0)
          send_gap = pick_gap();
      end
      if (!valid_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (segment_q.size() > 0) begin
          data_next = segment_q.pop_front();
          valid_next = 1'b1;
        end
      end
    end
    in_tvalid <= valid_next;
    in_tdata <= data_next;
  end

  // receiver and checker
  int pixels_seen = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit backpressure_done = 1'b0;

  always @(posedge clk) begin
    pixel_t want;
    logic   ready_next;
    ready_next = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        pixels_seen++;
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel x=%0d y=%0d last=%0b",
                 out_tdata[0 +: COORD_BITS], out_tdata[COORD_BITS +: COORD_BITS], out_tlast);
          mismatch_cnt++;
        end else begin
          want = pixel_q.pop_front();
          if (out_tdata[0 +: COORD_BITS] !== want.x) begin
            $error("pixel_x expected %0d got %0d", want.x, out_tdata[0 +: COORD_BITS]);
            mismatch_cnt++;
          end
          if (out_tdata[COORD_BITS +: COORD_BITS] !== want.y) begin
            $error("pixel_y expected %0d got %0d", want.y,
                   out_tdata[COORD_BITS +: COORD_BITS]);
            mismatch_cnt++;
          end
          if (out_tlast !== want.last) begin
            $error("last_pixel expected %0b got %0b", want.last, out_tlast);
            mismatch_cnt++;
          end
        end
      end
      // one long hold-off so the core stays busy and stalls its input
      if (!backpressure_done && pixels_seen >= 500) begin
        backpressure_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else begin
        ready_next = 1'b1;
        if (!(pixels_seen >= 1500 && pixels_seen < 2500) && $urandom_range(0, 3) == 0)
          stall_left = pick_gap();
      end
    end
    out_tready <= ready_next;
  end

  initial begin
    int sx, sy, ex, ey;
    // directed segments
    queue_segment(0, 0, 0, 0);
    queue_segment(63, 63, 63, 63);
    queue_segment(0, 0, 63, 0);
    queue_segment(63, 5, 0, 5);
    queue_segment(7, 0, 7, 63);
    queue_segment(7, 63, 7, 0);
    queue_segment(0, 0, 63, 63);
    queue_segment(0, 63, 63, 0);
    queue_segment(63, 63, 0, 0);
    queue_segment(63, 0, 0, 63);
    queue_segment(2, 10, 50, 30);
    queue_segment(2, 40, 50, 12);
    queue_segment(10, 3, 25, 60);
    queue_segment(10, 60, 25, 3);
    queue_segment(40, 50, 5, 20);
    queue_segment(0, 63, 63, 62);
    queue_segment(0, 0, 63, 1);
    queue_segment(0, 1, 63, 0);
    queue_segment(0, 62, 63, 63);
    queue_segment(62, 0, 63, 63);
    queue_segment(1, 63, 0, 0);
    queue_segment(21, 42, 22, 42);
    queue_segment(33, 17, 33, 16);
    // random segments
    repeat (190) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          sx = pick_coord(); sy = pick_coord();
          ex = near_coord(sx); ey = near_coord(sy);
        end
        2, 3: begin
          sx = $urandom_range(0, 63); sy = $urandom_range(0, 63);
          ex = $urandom_range(0, 63); ey = $urandom_range(0, 63);
        end
        4: begin
          sx = pick_coord(); sy = pick_coord();
          ex = pick_coord(); ey = pick_coord();
        end
        default: begin
          sx = $urandom_range(0, 63); sy = $urandom_range(0, 63);
          ex = $urandom_range(0, 63);
          ey = ($urandom_range(0, 1) == 0) ? sy : $urandom_range(0, 63);
          if ($urandom_range(0, 2) == 0) ex = sx;
        end
      endcase
      queue_segment(sx, sy, ex, ey);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (segment_q.size() != 0 || in_tvalid || pixel_q.size() != 0);
    repeat (100) @(negedge clk);

    if (mismatch_cnt == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
